>>> rtl/ttx_pkg.sv
package ttx_pkg;

    localparam int CHAR_W   = 8;
    localparam int GLYPH_W  = 9;
    localparam int COLOUR_W = 3;
    localparam int FLAGS_W  = 7;

    // attribute flag bit positions
    localparam int FLAG_DBLHI   = 0;
    localparam int FLAG_SEPGR   = 1;
    localparam int FLAG_FLASH   = 2;
    localparam int FLAG_BOX     = 3;
    localparam int FLAG_GRAPH   = 4;
    localparam int FLAG_CONCEAL = 5;
    localparam int FLAG_HOLD    = 6;

    localparam logic [COLOUR_W-1:0] COLOUR_WHITE = 3'd7;
    localparam logic [COLOUR_W-1:0] COLOUR_BLACK = 3'd0;
    localparam logic [CHAR_W-1:0]   SPACE_CHAR   = 8'd32;

    localparam logic [GLYPH_W-1:0]  MOSAIC_OFS_HI  = 9'd64;
    localparam logic [GLYPH_W-1:0]  MOSAIC_OFS_LO  = 9'd96;
    localparam logic [GLYPH_W-1:0]  MOSAIC_OFS_SEP = 9'd64;

    // single-function control codes (low 5 bits of a byte below 32)
    localparam logic [4:0] CTL_FLASH_ON   = 5'h08;
    localparam logic [4:0] CTL_FLASH_OFF  = 5'h09;
    localparam logic [4:0] CTL_BOX_ON     = 5'h0a;
    localparam logic [4:0] CTL_BOX_OFF    = 5'h0b;
    localparam logic [4:0] CTL_NORMAL_HT  = 5'h0c;
    localparam logic [4:0] CTL_DOUBLE_HT  = 5'h0d;
    localparam logic [4:0] CTL_CONCEAL    = 5'h18;
    localparam logic [4:0] CTL_SEP_ON     = 5'h19;
    localparam logic [4:0] CTL_SEP_OFF    = 5'h1a;
    localparam logic [4:0] CTL_BLACK_BG   = 5'h1c;
    localparam logic [4:0] CTL_HOLD_ON    = 5'h1e;
    localparam logic [4:0] CTL_HOLD_OFF   = 5'h1f;

    // colour-set groups, selected by code bits 4:3
    localparam logic [1:0] GRP_ALPHA_COLOUR = 2'b00;
    localparam logic [1:0] GRP_GRAPH_COLOUR = 2'b10;

endpackage

>>> rtl/teletext_attribute_decoder.sv
// Teletext serial attribute decoder.
// Input channel: i_valid / o_ready with i_char_code, i_row_start, i_flash_blank,
// one character cell per transfer. i_row_start marks the first cell of a row
// and clears the row attributes before that byte is decoded.
// Output channel: o_valid / i_ready with o_glyph, o_cell_colour and
// o_double_height, one result per input transfer, in order.
// The result of a transfer accepted at one edge is registered and is on the
// outputs after that edge. Throughput is one cell per cycle while the
// receiver takes each result; the attribute registers and the output register
// are the only storage, and the decode between them is a single pass of byte
// compares and 9-bit adds. When the receiver stalls, the result stays in the
// output register; o_ready is high only if that register is empty or emptied
// in the same cycle, so a new cell enters in the cycle the old result is taken.
// Reset (synchronous, active low) clears the attributes, sets the foreground
// to white, the background to black, the held character to space, and empties
// the output register.
module teletext_attribute_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [ttx_pkg::CHAR_W-1:0]     i_char_code,
    input  logic                           i_row_start,
    input  logic                           i_flash_blank,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ttx_pkg::GLYPH_W-1:0]    o_glyph,
    output logic [2*ttx_pkg::COLOUR_W-1:0] o_cell_colour,
    output logic                           o_double_height
);
    import ttx_pkg::*;

    logic [FLAGS_W-1:0]  r_flags,  n_flags;
    logic [COLOUR_W-1:0] r_fore,   n_fore;
    logic [COLOUR_W-1:0] r_back,   n_back;
    logic [CHAR_W-1:0]   r_held,   n_held;
    logic                r_valid;
    logic [GLYPH_W-1:0]  r_glyph,  n_glyph;
    logic [2*COLOUR_W-1:0] r_colour, n_colour;
    logic                r_dblhi;

    logic                in_fire;
    logic [CHAR_W-1:0]   shown;
    logic [GLYPH_W-1:0]  mosaic_ofs;

    assign o_ready = !r_valid || i_ready;
    assign in_fire = i_valid && o_ready;

    always_comb begin
        n_flags    = i_row_start ? '0 : r_flags;
        n_fore     = i_row_start ? COLOUR_WHITE : r_fore;
        n_held     = i_row_start ? SPACE_CHAR : r_held;
        n_back     = r_back;
        shown      = i_char_code;
        mosaic_ofs = '0;

        // control codes
        if (i_char_code[7:5] == 3'b000) begin
            if (i_char_code[4:3] == GRP_ALPHA_COLOUR && i_char_code[2:0] != 3'd0) begin
                n_fore                = i_char_code[2:0];
                n_flags[FLAG_GRAPH]   = 1'b0;
                n_flags[FLAG_CONCEAL] = 1'b0;
            end else if (i_char_code[4:3] == GRP_GRAPH_COLOUR
                         && i_char_code[2:0] != 3'd0) begin
                n_fore                = i_char_code[2:0];
                n_flags[FLAG_GRAPH]   = 1'b1;
                n_flags[FLAG_CONCEAL] = 1'b0;
            end else begin
                unique case (i_char_code[4:0])
                    CTL_FLASH_ON:  n_flags[FLAG_FLASH]   = 1'b1;
                    CTL_FLASH_OFF: n_flags[FLAG_FLASH]   = 1'b0;
                    CTL_BOX_ON:    n_flags[FLAG_BOX]     = 1'b1;
                    CTL_BOX_OFF:   n_flags[FLAG_BOX]     = 1'b0;
                    CTL_NORMAL_HT: n_flags[FLAG_DBLHI]   = 1'b0;
                    CTL_DOUBLE_HT: n_flags[FLAG_DBLHI]   = 1'b1;
                    CTL_CONCEAL:   n_flags[FLAG_CONCEAL] = 1'b1;
                    CTL_SEP_ON:    n_flags[FLAG_SEPGR]   = 1'b1;
                    CTL_SEP_OFF:   n_flags[FLAG_SEPGR]   = 1'b0;
                    CTL_BLACK_BG:  n_back                = COLOUR_BLACK;
                    CTL_HOLD_ON:   n_flags[FLAG_HOLD]    = 1'b1;
                    CTL_HOLD_OFF:  n_flags[FLAG_HOLD]    = 1'b0;
                    default: ;
                endcase
            end
            shown = n_flags[FLAG_HOLD] ? n_held : SPACE_CHAR;
        end

        // blanking, else the cell becomes the new held character
        priority if (n_flags[FLAG_CONCEAL]
                     || (n_flags[FLAG_FLASH] && i_flash_blank)) begin
            n_glyph = GLYPH_W'(SPACE_CHAR);
        end else begin
            n_held = shown;
            if (n_flags[FLAG_GRAPH] && shown[5]) begin
                mosaic_ofs = (shown[6] ? MOSAIC_OFS_HI : MOSAIC_OFS_LO)
                             + (n_flags[FLAG_SEPGR] ? MOSAIC_OFS_SEP : '0);
            end
            n_glyph = GLYPH_W'(shown) + mosaic_ofs;
        end

        // colour order swaps for the upper glyph half
        n_colour = n_glyph[7] ? {n_fore, n_back} : {n_back, n_fore};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_fore  <= COLOUR_WHITE;
            r_back  <= COLOUR_BLACK;
            r_held  <= SPACE_CHAR;
            r_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_flags <= n_flags;
                r_fore  <= n_fore;
                r_back  <= n_back;
                r_held  <= n_held;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_glyph  <= n_glyph;
            r_colour <= n_colour;
            r_dblhi  <= n_flags[FLAG_DBLHI];
        end
    end

    assign o_valid         = r_valid;
    assign o_glyph         = r_glyph;
    assign o_cell_colour   = r_colour;
    assign o_double_height = r_dblhi;

    // a cell taken in always leaves a result behind
    a_fire_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_valid)
        else $error("accepted cell produced no result");

    // a printable first cell of a row leaves default attributes
    a_row_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_row_start && i_char_code[7:5] != 3'b000)
        |=> (r_flags == '0 && r_fore == COLOUR_WHITE))
        else $error("row start did not clear attributes");

    // the background can only ever be black, so one colour half is always zero
    a_back_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_glyph[7] ? (r_colour[2:0] == COLOUR_BLACK)
                                : (r_colour[5:3] == COLOUR_BLACK)))
        else $error("background colour not black");

    // the output register is only reloaded by an input transfer
    a_no_reload_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_glyph) && $stable(r_colour)))
        else $error("result changed while stalled");

endmodule
